// ===== rtl/ddo_pkg.sv =====
// shared constants, widths and helper functions for the odometry unit
package ddo_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 16;

    // shared unit widths
    localparam int unsigned MUL_AW = 48;
    localparam int unsigned MUL_BW = 32;
    localparam int unsigned MUL_PW = 64;
    localparam int unsigned DIV_NW = 64;
    localparam int unsigned DIV_DW = 21;
    localparam int unsigned SQ_RW  = 52;
    localparam int unsigned SQ_QW  = SQ_RW / 2;
    localparam int unsigned COR_W  = 48;
    localparam int unsigned ANG_W  = 20;

    // register reset values
    localparam logic [31:0] MPC_RESET = 32'd10120;
    localparam logic [18:0] TW_RESET  = 19'd29884;
    localparam logic [15:0] THR_RESET = 16'd200;

    // configuration register indexes
    localparam logic [1:0] CFG_MPC = 2'd0;
    localparam logic [1:0] CFG_TW  = 2'd1;
    localparam logic [1:0] CFG_THR = 2'd2;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 20'sd411775;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [DIV_DW-1:0]       TWO_PI_DEN  = 21'd411775;
    localparam logic [MUL_BW-1:0]       K_Q30       = 32'd652032874;
    localparam logic [MUL_BW-1:0]       US_PER_S    = 32'd1000000;

    // arctangent of 2^-i in q16.16
    function automatic logic [16:0] atan_lut(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30385;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // apply sign to a magnitude and saturate to 32 bits
    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] v;
        if (!neg) begin
            v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            v = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
        end
        return v;
    endfunction

    // signed remainder of a 2*pi reduction folded into +-pi
    function automatic logic signed [ANG_W-1:0] wrap_rem(input logic neg,
                                                         input logic [18:0] rem);
        logic signed [ANG_W-1:0] r;
        r = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
        if (r > PI_Q16) begin
            r = r - TWO_PI_Q16;
        end else if (r < -PI_Q16) begin
            r = r + TWO_PI_Q16;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ddo_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ddo_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ddo_pkg::MUL_AW-1:0]  i_a,
    input  logic [ddo_pkg::MUL_BW-1:0]  i_b,
    output logic [ddo_pkg::MUL_PW-1:0]  o_p,
    output logic                        o_done
);
    import ddo_pkg::*;

    localparam int unsigned CW = $clog2(MUL_BW);
    localparam logic [CW-1:0] LAST = CW'(MUL_BW - 1);

    logic [MUL_AW-1:0] r_a;
    logic [MUL_BW-1:0] r_b;
    logic [MUL_PW-1:0] r_p;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // msb first: shift the partial product and add the multiplicand
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {r_p[MUL_PW-2:0], 1'b0} + (r_b[MUL_BW-1] ? MUL_PW'(r_a) : '0);
            r_b <= {r_b[MUL_BW-2:0], 1'b0};
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

// ===== rtl/ddo_div.sv =====
// restoring divider, one quotient bit per cycle
module ddo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ddo_pkg::DIV_NW-1:0]  i_num,
    input  logic [ddo_pkg::DIV_DW-1:0]  i_den,
    output logic [ddo_pkg::DIV_NW-1:0]  o_quo,
    output logic [ddo_pkg::DIV_DW-1:0]  o_rem,
    output logic                        o_done
);
    import ddo_pkg::*;

    localparam int unsigned CW = $clog2(DIV_NW);
    localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0] w_t;
    logic [DIV_DW:0] w_sub;
    logic            w_ge;

    assign w_t   = {r_rem, r_q[DIV_NW-1]};
    assign w_ge  = (w_t >= {1'b0, r_den});
    assign w_sub = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of r_q while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIV_DW-1:0] : w_t[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
        end
    end

    assign o_quo  = r_q;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== rtl/ddo_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
module ddo_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ddo_pkg::SQ_RW-1:0]  i_val,
    output logic [ddo_pkg::SQ_QW-1:0]  o_root,
    output logic                       o_done
);
    import ddo_pkg::*;

    localparam int unsigned CW = $clog2(SQ_QW);
    localparam logic [CW-1:0] LAST = CW'(SQ_QW - 1);
    localparam int unsigned RMW = SQ_QW + 2;

    logic [SQ_RW-1:0] r_v;
    logic [RMW-1:0]   r_rem;
    logic [SQ_QW-1:0] r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RMW:0] w_t;
    logic [RMW:0] w_trial;
    logic [RMW:0] w_sub;
    logic         w_ge;

    assign w_t     = {r_rem[RMW-2:0], r_v[SQ_RW-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_sub   = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[SQ_RW-3:0], 2'b00};
            r_rem  <= w_ge ? w_sub[RMW-1:0] : w_t[RMW-1:0];
            r_root <= {r_root[SQ_QW-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== rtl/ddo_cordic.sv =====
// rotation-mode cordic, one micro-rotation per cycle
module ddo_cordic #(
    parameter int unsigned STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ddo_pkg::COR_W-1:0]  i_x0,
    input  logic signed [ddo_pkg::ANG_W-1:0]  i_theta,
    output logic signed [ddo_pkg::COR_W-1:0]  o_x,
    output logic signed [ddo_pkg::COR_W-1:0]  o_y,
    output logic                              o_done
);
    import ddo_pkg::*;

    localparam int unsigned CW = $clog2(STEPS);
    localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

    logic signed [COR_W-1:0] r_x;
    logic signed [COR_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [CW-1:0]           r_i;
    logic                    r_busy;
    logic                    r_done;

    logic signed [COR_W-1:0] w_xs;
    logic signed [COR_W-1:0] w_ys;
    logic signed [ANG_W-1:0] w_at;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed({3'b000, atan_lut(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quarter-turn pre-rotation keeps the residual angle within +-pi/2
            if (i_theta > HALF_PI_Q16) begin
                r_x <= '0;
                r_y <= i_x0;
                r_z <= i_theta - HALF_PI_Q16;
            end else if (i_theta < -HALF_PI_Q16) begin
                r_x <= '0;
                r_y <= -i_x0;
                r_z <= i_theta + HALF_PI_Q16;
            end else begin
                r_x <= i_x0;
                r_y <= '0;
                r_z <= i_theta;
            end
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_done = r_done;

endmodule

// ===== rtl/differential_drive_odometry_unit.sv =====
// differential-drive odometry: sequencer, shared serial units and pose state
// One item at a time: the first item after reset only stores the encoder counts and
// returns a result with valid_res low. Every later item runs a fixed sequence on one
// bit-serial multiplier, one restoring divider, a square-root unit and the cordic,
// each operation passing through an issue and a wait state: eight products, seven
// quotients, one root and one rotation, with most of the time spent in the divider.
// A new item is taken as soon as the previous result sits in the output register,
// even while that result waits.
module differential_drive_odometry_unit #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    input  logic [19:0]        i_period_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_valid_res,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [14:0] o_heading,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        OP_DL, OP_DR, OP_LINM, OP_LIND, OP_AD, OP_ANGM, OP_ANGD, OP_U, OP_A4,
        OP_U12, OP_A360, OP_SQRT, OP_LEN, OP_X0, OP_TH, OP_COR, OP_NH
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [31:0]        r_mpc;
    logic [18:0]        r_tw;
    logic [15:0]        r_thr;
    logic [31:0]        r_last_l;
    logic [31:0]        r_last_r;
    logic               r_primed;
    logic [31:0]        r_acc_x;
    logic [31:0]        r_acc_y;
    logic [15:0]        r_acc_h;
    logic               r_res_ok;
    logic               r_o_valid;

    logic [19:0]        r_per;
    logic signed [31:0] r_dlc;
    logic signed [31:0] r_drc;
    logic signed [47:0] r_dl;
    logic signed [47:0] r_dr;
    logic [31:0]        r_lin;
    logic signed [41:0] r_a;
    logic [31:0]        r_ang;
    logic [30:0]        r_u;
    logic [44:0]        r_a4;
    logic signed [37:0] r_f;
    logic [SQ_QW-1:0]   r_g;
    logic signed [31:0] r_len;
    logic signed [COR_W-1:0] r_x0;
    logic signed [ANG_W-1:0] r_th;
    logic signed [15:0] r_nh;

    logic               r_o_res;
    logic [31:0]        r_o_lin;
    logic [31:0]        r_o_ang;
    logic [31:0]        r_o_x;
    logic [31:0]        r_o_y;
    logic [14:0]        r_o_h;

    // shared unit connections
    logic [MUL_AW-1:0] w_mul_a;
    logic [MUL_BW-1:0] w_mul_b;
    logic              w_mul_neg;
    logic [MUL_PW-1:0] mul_p;
    logic              mul_done;
    logic [DIV_NW-1:0] w_div_n;
    logic [DIV_DW-1:0] w_div_d;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_DW-1:0] div_r;
    logic              div_done;
    logic [SQ_RW-1:0]  w_sq_v;
    logic [SQ_QW-1:0]  sq_root;
    logic              sqrt_done;
    logic signed [COR_W-1:0] cor_x;
    logic signed [COR_W-1:0] cor_y;
    logic              cor_done;
    logic              w_use_mul;
    logic              w_use_div;
    logic              w_use_sqrt;
    logic              w_use_cor;
    logic              w_issue;
    logic              w_unit_done;

    // derived values
    logic [31:0]        w_lnow;
    logic [31:0]        w_abs_dlc;
    logic [31:0]        w_abs_drc;
    logic signed [48:0] w_s;
    logic signed [48:0] w_diff;
    logic [48:0]        w_abs_s;
    logic [48:0]        w_abs_diff;
    logic               w_s_big;
    logic               w_d_big;
    logic [40:0]        w_abs_a;
    logic [23:0]        w_ap;
    logic signed [47:0] w_m;
    logic [47:0]        w_absm;
    logic               w_m_big;
    logic signed [32:0] w_dd;
    logic [32:0]        w_abs_dd;
    logic               w_straight;
    logic [30:0]        w_abs_len;
    logic [30:0]        w_lenmag;
    logic [18:0]        w_w;
    logic signed [ANG_W-1:0] w_h16;
    logic signed [41:0] w_vth;
    logic signed [41:0] w_vnh;
    logic [41:0]        w_abs_vth;
    logic [41:0]        w_abs_vnh;
    logic signed [MUL_PW-1:0] w_psigned;
    logic [40:0]        w_qa;
    logic signed [ANG_W-1:0] w_wnh;
    logic signed [ANG_W-1:0] w_nh_r;
    logic [31:0]        w_new_x;
    logic [31:0]        w_new_y;
    logic               w_load_out;
    logic signed [COR_W-1:0] w_xr;
    logic signed [COR_W-1:0] w_yr;

    assign w_lnow    = 32'd0 - i_left_position;
    assign w_abs_dlc = r_dlc[31] ? 32'(-r_dlc) : r_dlc;
    assign w_abs_drc = r_drc[31] ? 32'(-r_drc) : r_drc;

    assign w_s        = {r_dl[47], r_dl} + {r_dr[47], r_dr};
    assign w_diff     = {r_dr[47], r_dr} - {r_dl[47], r_dl};
    assign w_abs_s    = w_s[48] ? 49'(-w_s) : w_s;
    assign w_abs_diff = w_diff[48] ? 49'(-w_diff) : w_diff;
    assign w_s_big    = |w_abs_s[48:43];
    assign w_d_big    = |w_abs_diff[48:46];

    assign w_abs_a = r_a[41] ? 41'(-r_a) : r_a[40:0];
    assign w_ap    = (w_abs_a > 41'h80_0000) ? 24'h80_0000 : w_abs_a[23:0];

    assign w_m     = w_s[48:1];
    assign w_absm  = w_m[47] ? 48'(-w_m) : w_m;
    assign w_m_big = |w_absm[47:32];

    assign w_dd       = {r_dlc[31], r_dlc} - {r_drc[31], r_drc};
    assign w_abs_dd   = w_dd[32] ? 33'(-w_dd) : w_dd;
    assign w_straight = (w_abs_dd < 33'(r_thr)) && r_drc[31];
    assign w_lenmag   = (w_m_big || (|mul_p[63:47])) ? 31'h7FFF_FFFF : mul_p[46:16];
    assign w_abs_len  = r_len[31] ? 31'(-r_len) : r_len[30:0];

    assign w_w = (r_tw == '0) ? 19'd1 : r_tw;

    assign w_h16     = $signed({r_acc_h, 4'b0000});
    assign w_vth     = 42'(w_h16) + (r_a >>> 1);
    assign w_vnh     = 42'(w_h16) + r_a;
    assign w_abs_vth = w_vth[41] ? 42'(-w_vth) : w_vth;
    assign w_abs_vnh = w_vnh[41] ? 42'(-w_vnh) : w_vnh;

    assign w_psigned = w_mul_neg ? -$signed(mul_p) : $signed(mul_p);
    assign w_qa      = (div_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : div_q[40:0];
    assign w_wnh     = wrap_rem(w_vnh[41], div_r[18:0]);
    assign w_nh_r    = (w_wnh + 20'sd8) >>> 4;

    // round half up to q16.16 meters
    assign w_xr    = (cor_x + 48'sd8192) >>> 14;
    assign w_yr    = (cor_y + 48'sd8192) >>> 14;
    assign w_new_x = r_acc_x + w_xr[31:0];
    assign w_new_y = r_acc_y + w_yr[31:0];

    assign w_issue     = (r_state == S_ISSUE);
    assign w_unit_done = mul_done | div_done | sqrt_done | cor_done;
    assign w_load_out  = (r_state == S_DONE) && (!r_o_valid || !i_stall);

    // operand selection for the current operation
    always_comb begin
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_mul_neg  = 1'b0;
        w_div_n    = '0;
        w_div_d    = 21'd1;
        w_sq_v     = '0;
        w_use_mul  = 1'b0;
        w_use_div  = 1'b0;
        w_use_sqrt = 1'b0;
        w_use_cor  = 1'b0;
        unique case (r_op)
            OP_DL: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_abs_dlc);
                w_mul_b   = r_mpc;
                w_mul_neg = r_dlc[31];
            end
            OP_DR: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_abs_drc);
                w_mul_b   = r_mpc;
                w_mul_neg = r_drc[31];
            end
            OP_LINM: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_abs_s[42:0]);
                w_mul_b   = US_PER_S;
            end
            OP_LIND: begin
                w_use_div = 1'b1;
                w_div_n   = mul_p;
                w_div_d   = {r_per, 1'b0};
            end
            OP_AD: begin
                w_use_div = 1'b1;
                w_div_n   = DIV_NW'({w_abs_diff[45:0], 16'h0000});
                w_div_d   = DIV_DW'(w_w);
            end
            OP_ANGM: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_abs_a);
                w_mul_b   = US_PER_S;
            end
            OP_ANGD: begin
                w_use_div = 1'b1;
                w_div_n   = mul_p;
                w_div_d   = {1'b0, r_per};
            end
            OP_U: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_ap);
                w_mul_b   = MUL_BW'(w_ap);
            end
            OP_A4: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(r_u);
                w_mul_b   = MUL_BW'(r_u);
            end
            OP_U12: begin
                w_use_div = 1'b1;
                w_div_n   = DIV_NW'(r_u);
                w_div_d   = 21'd12;
            end
            OP_A360: begin
                w_use_div = 1'b1;
                w_div_n   = DIV_NW'(r_a4);
                w_div_d   = 21'd360;
            end
            OP_SQRT: begin
                w_use_sqrt = 1'b1;
                w_sq_v     = {r_f[35:0], 16'h0000};
            end
            OP_LEN: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_absm[31:0]);
                w_mul_b   = MUL_BW'(r_g);
            end
            OP_X0: begin
                w_use_mul = 1'b1;
                w_mul_a   = MUL_AW'(w_abs_len);
                w_mul_b   = K_Q30;
                w_mul_neg = r_len[31];
            end
            OP_TH: begin
                w_use_div = 1'b1;
                w_div_n   = DIV_NW'(w_abs_vth);
                w_div_d   = TWO_PI_DEN;
            end
            OP_COR: begin
                w_use_cor = 1'b1;
            end
            OP_NH: begin
                w_use_div = 1'b1;
                w_div_n   = DIV_NW'(w_abs_vnh);
                w_div_d   = TWO_PI_DEN;
            end
            default: begin
            end
        endcase
    end

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_issue && w_use_mul),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_p     (mul_p),
        .o_done  (mul_done)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_issue && w_use_div),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_quo   (div_q),
        .o_rem   (div_r),
        .o_done  (div_done)
    );

    ddo_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_issue && w_use_sqrt),
        .i_val   (w_sq_v),
        .o_root  (sq_root),
        .o_done  (sqrt_done)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_issue && w_use_cor),
        .i_x0    (r_x0),
        .i_theta (r_th),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_done  (cor_done)
    );

    // control, configuration and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_DL;
            r_mpc     <= MPC_RESET;
            r_tw      <= TW_RESET;
            r_thr     <= THR_RESET;
            r_last_l  <= '0;
            r_last_r  <= '0;
            r_primed  <= 1'b0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_acc_h   <= '0;
            r_res_ok  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MPC: r_mpc <= i_cfg_data;
                    CFG_TW:  r_tw  <= i_cfg_data[18:0];
                    CFG_THR: r_thr <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last_l <= w_lnow;
                        r_last_r <= i_right_position;
                        r_primed <= 1'b1;
                        r_res_ok <= r_primed;
                        r_op     <= OP_DL;
                        r_state  <= r_primed ? S_ISSUE : S_DONE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_unit_done) begin
                        if (r_op == OP_NH) begin
                            r_state <= S_DONE;
                        end else begin
                            r_op    <= t_op'(r_op + 5'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        if (r_res_ok) begin
                            r_acc_x <= w_new_x;
                            r_acc_y <= w_new_y;
                            r_acc_h <= r_nh;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working values and output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_dlc <= $signed(w_lnow - r_last_l);
            r_drc <= $signed(i_right_position - r_last_r);
            r_per <= (i_period_us == '0) ? 20'd1 : i_period_us;
        end

        if (r_state == S_WAIT && w_unit_done) begin
            case (r_op)
                OP_DL:   r_dl <= w_psigned[63:16];
                OP_DR:   r_dr <= w_psigned[63:16];
                OP_LIND: begin
                    if (w_s_big) begin
                        r_lin <= w_s[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        r_lin <= sat32(w_s[48], div_q);
                    end
                end
                OP_AD: begin
                    if (w_d_big) begin
                        r_a <= w_diff[48] ? -42'sh100_0000_0000 : 42'sh100_0000_0000;
                    end else begin
                        r_a <= w_diff[48] ? -$signed({1'b0, w_qa}) : $signed({1'b0, w_qa});
                    end
                end
                OP_ANGD: r_ang <= sat32(r_a[41], div_q);
                OP_U:    r_u   <= mul_p[46:16];
                OP_A4:   r_a4  <= mul_p[60:16];
                OP_U12:  r_f   <= 38'sd65536 - $signed({11'b0, div_q[26:0]});
                OP_A360: r_f   <= r_f + $signed({1'b0, div_q[36:0]});
                OP_SQRT: r_g   <= sq_root;
                OP_LEN: begin
                    // only nearly straight reverse motion gives a negative chord
                    r_len <= w_straight ? -$signed({1'b0, w_lenmag})
                                        : $signed({1'b0, w_lenmag});
                end
                OP_X0:   r_x0 <= w_psigned[63:16];
                OP_TH:   r_th <= wrap_rem(w_vth[41], div_r[18:0]);
                OP_NH:   r_nh <= w_nh_r[15:0];
                default: begin
                end
            endcase
        end

        if (w_load_out) begin
            r_o_res <= r_res_ok;
            r_o_lin <= r_res_ok ? r_lin : '0;
            r_o_ang <= r_res_ok ? r_ang : '0;
            r_o_x   <= r_res_ok ? w_new_x : '0;
            r_o_y   <= r_res_ok ? w_new_y : '0;
            r_o_h   <= r_res_ok ? r_nh[14:0] : '0;
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_valid_res        = r_o_res;
    assign o_linear_velocity  = r_o_lin;
    assign o_angular_velocity = r_o_ang;
    assign o_pos_x            = r_o_x;
    assign o_pos_y            = r_o_y;
    assign o_heading          = r_o_h;

`ifndef SYNTH
    a_one_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_done, div_done, sqrt_done, cor_done}))
        else $error("two arithmetic units finished in the same cycle");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_ISSUE) |-> !w_unit_done)
        else $error("unit finished while the sequencer was not waiting");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not blocked after a transfer");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading <= 15'sd12868 && o_heading >= -15'sd12868))
        else $error("heading out of range");
`endif

endmodule
